FILE: src/bf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bf_pkg
// shared types and constants for the blowfish block cipher
// ----------------------------------------------------------------------------
package bf_pkg;

  localparam int ROUNDS_DEF = 16;
  localparam int SBOX_WORDS = 'h400;
  localparam int SBOX_SIZE  = 'h100;
  localparam int SBOX_AW    = 8;
  localparam int P_WORDS    = 18;
  localparam int P_AW       = 5;
  localparam int IDX_W      = 11;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_ENC  = 2'd1;
  localparam logic [1:0] FUNC_DEC  = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [IDX_W-1:0] table_index;
    logic [31:0]      table_word;
    logic [31:0]      left_half;
    logic [31:0]      right_half;
  } req_word_t;

  typedef struct packed {
    logic [31:0] left_out;
    logic [31:0] right_out;
  } rsp_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic            start;
    logic            prime;
    logic            run;
    logic            last;
    logic            finish;
    logic            out_load;
    logic [P_AW-1:0] p_addr;
  } ctl_t;

endpackage
`default_nettype wire

FILE: src/blowfish_block_cipher.sv
`default_nettype none
// a block runs through subkey prime, the rounds and whitening before another starts
// while idle, the cipher takes one table load word per cycle
// each round is one pass through the four s-box memories and the round function
// subkey prime and whitening each have a state, a held result word stalls whitening
// reset clears the sequencer and the result valid; tables are undefined until loaded
// ----------------------------------------------------------------------------
// blowfish_block_cipher
// 64-bit blowfish cipher with s-boxes and p-array held in loadable memories
// ----------------------------------------------------------------------------
module blowfish_block_cipher #(
  parameter int ROUNDS = bf_pkg::ROUNDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire bf_pkg::req_word_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output bf_pkg::rsp_word_t      rsp
);
  import bf_pkg::*;

  ctl_t        ctl;
  logic        out_free;
  logic        load;
  logic [3:0]  s_we;
  logic        p_we;
  logic [31:0] s_rdata [4];
  logic [31:0] p_rdata;
  logic [31:0] hx;
  logic [31:0] hl;
  logic [31:0] f;
  logic [31:0] nl;
  logic [31:0] xn;

  assign out_free = !rsp_valid || rsp_ready;
  assign load     = req_valid && req_ready && (req.func == FUNC_LOAD);
  assign p_we     = load && req.table_index[IDX_W-1]
                    && (req.table_index[IDX_W-2:P_AW] == '0)
                    && (req.table_index[P_AW-1:0] < P_AW'(P_WORDS));

  bf_seq #(
    .ROUNDS (ROUNDS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_func  (req.func),
    .out_free  (out_free),
    .req_ready (req_ready),
    .ctl       (ctl)
  );

  // s-box n is addressed by byte 3-n of the round input
  for (genvar n = 0; n < 4; n++) begin : g_sbox
    assign s_we[n] = load && !req.table_index[IDX_W-1]
                     && (req.table_index[SBOX_AW+1:SBOX_AW] == 2'(n));

    bf_ram #(
      .WIDTH (32),
      .DEPTH (SBOX_SIZE)
    ) u_sbox (
      .clk   (clk),
      .we    (s_we[n]),
      .waddr (req.table_index[SBOX_AW-1:0]),
      .wdata (req.table_word),
      .raddr (xn[8*(3-n) +: 8]),
      .rdata (s_rdata[n])
    );
  end

  bf_ram #(
    .WIDTH (32),
    .DEPTH (P_WORDS)
  ) u_parr (
    .clk   (clk),
    .we    (p_we),
    .waddr (req.table_index[P_AW-1:0]),
    .wdata (req.table_word),
    .raddr (ctl.p_addr),
    .rdata (p_rdata)
  );

  assign f  = ((s_rdata[0] + s_rdata[1]) ^ s_rdata[2]) + s_rdata[3];
  assign nl = hl ^ f;
  assign xn = (ctl.prime ? hx : nl) ^ p_rdata;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      hx <= req.left_half;
      hl <= req.right_half;
    end else if (ctl.prime) begin
      hx <= xn;
    end else if (ctl.run) begin
      if (ctl.last) begin
        hx <= hx ^ p_rdata;
        hl <= nl;
      end else begin
        hx <= xn;
        hl <= hx;
      end
    end
    if (ctl.out_load) begin
      rsp.left_out  <= hx;
      rsp.right_out <= hl ^ p_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_start_prime : assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> ctl.prime)
    else $error("cipher start not followed by subkey prime");

  a_last_finish : assert property (@(posedge clk) disable iff (rst)
    ctl.last |=> ctl.finish)
    else $error("last round not followed by whitening");

  a_one_phase : assert property (@(posedge clk) disable iff (rst)
    $onehot({req_ready, ctl.prime, ctl.run, ctl.finish}))
    else $error("sequencer phases overlap");

  a_no_write_busy : assert property (@(posedge clk) disable iff (rst)
    (ctl.prime || ctl.run || ctl.finish) |-> (s_we == '0 && !p_we))
    else $error("table write during a block");

  a_out_load : assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> rsp_valid)
    else $error("result word not presented");
`endif

endmodule
`default_nettype wire

FILE: src/bf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bf_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module bf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/bf_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bf_seq
// round sequencer: state machine, round count and subkey address order
// ----------------------------------------------------------------------------
module bf_seq #(
  parameter int ROUNDS = bf_pkg::ROUNDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire logic [1:0]  req_func,
  input  wire logic        out_free,
  output logic             req_ready,
  output bf_pkg::ctl_t     ctl
);
  import bf_pkg::*;

  localparam int CW = $clog2(ROUNDS);
  localparam logic [CW-1:0]   CNT_LAST = CW'(ROUNDS - 1);
  localparam logic [P_AW-1:0] RK0      = P_AW'(ROUNDS);
  localparam logic [P_AW-1:0] RK1      = P_AW'(ROUNDS + 1);

  state_t          state, state_next;
  logic [CW-1:0]   cnt, cnt_next;
  logic            dec, dec_next;
  logic            dec_now;
  logic [P_AW-1:0] step;

  function automatic logic [P_AW-1:0] key_addr(input logic [P_AW-1:0] j, input logic d);
    if (j < RK0) begin
      return d ? RK1 - j : j;
    end else if (j == RK0) begin
      return d ? P_AW'(0) : RK1;
    end else begin
      return d ? P_AW'(1) : RK0;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      dec   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      dec   <= dec_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    dec_next   = dec;
    dec_now    = dec;
    req_ready  = 1'b0;
    step       = '0;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        dec_now   = (req_func == FUNC_DEC);
        if (req_valid && (req_func == FUNC_ENC || req_func == FUNC_DEC)) begin
          ctl.start  = 1'b1;
          state_next = ST_PRIME;
          dec_next   = dec_now;
          cnt_next   = '0;
        end
      end
      ST_PRIME: begin
        ctl.prime  = 1'b1;
        step       = P_AW'(1);
        state_next = ST_RUN;
      end
      ST_RUN: begin
        ctl.run = 1'b1;
        step    = P_AW'(cnt) + P_AW'(2);
        if (cnt == CNT_LAST) begin
          ctl.last   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FINISH: begin
        ctl.finish = 1'b1;
        step       = RK1;
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    ctl.p_addr = key_addr(step, dec_now);
  end

endmodule
`default_nettype wire
